/* sv/float_scale_by_power_of_two_defines.svh */
// ----------------------------------------------------------------------------
// float_scale_by_power_of_two_defines
// Assertion macros shared by the scaling block.
// ----------------------------------------------------------------------------
`ifndef FLOAT_SCALE_BY_POWER_OF_TWO_DEFINES_SVH
`define FLOAT_SCALE_BY_POWER_OF_TWO_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define FSP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define FSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/fsp_pkg.sv */
// ----------------------------------------------------------------------------
// fsp_pkg
// Types and constants for the power-of-two float scaling datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package fsp_pkg;

  localparam int F32_MANT = 23;
  localparam int F64_MANT = 52;
  localparam logic [10:0] F32_BIAS = 11'd127;
  localparam logic [10:0] F64_BIAS = 11'd1023;
  localparam logic [10:0] F32_EXPMAX = 11'd255;
  localparam logic [10:0] F64_EXPMAX = 11'd2047;
  localparam logic PREC_SINGLE = 1'b0;
  localparam logic PREC_DOUBLE = 1'b1;

  // One input word
  typedef struct packed {
    logic        precision;
    logic [63:0] value;
    logic [31:0] scale_factor;
  } fsp_in_t;

  // Count leading zeros of a 53-bit significand field
  function automatic logic [5:0] clz53(input logic [52:0] x);
    logic [5:0] n;
    logic       found;
    n = 6'd53;
    found = 1'b0;
    for (int i = 52; i >= 0; i--) begin
      if (x[i] && !found) begin
        n = 6'(52 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

/* sv/fsp_stream_if.sv */
// ----------------------------------------------------------------------------
// fsp_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface fsp_stream_if #(parameter type T = logic [63:0]);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/float_scale_by_power_of_two.sv */
// ----------------------------------------------------------------------------
// float_scale_by_power_of_two
// Scales a binary32/binary64 bit pattern by a power of two.
// ----------------------------------------------------------------------------
// Usage: words enter on in_ch (precision, value, scale_factor) and results
// leave on out_ch (scaled bit pattern, binary32 in the low half).
// An accepted word lands in an input register; the scaling logic sits
// between that register and the result register, so out_ch.valid rises
// when the result register takes the word, which waits while out_ch is
// stalled. One word per cycle is sustained while out_ch does not stall,
// set by the single-pass datapath. The two registers form a two-stage
// pipeline: when out_ch stalls, a stage only loads when the stage
// after it is empty or moving, so in_ch stays ready while any slot is
// free. Reset clears both valid flags; nothing else needs clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "float_scale_by_power_of_two_defines.svh"
module float_scale_by_power_of_two (
  input logic        clk,
  input logic        rst,
  fsp_stream_if.sink   in_ch,
  fsp_stream_if.source out_ch
);
  import fsp_pkg::*;

  logic        in_vld;
  fsp_in_t     in_reg;
  logic        out_vld;
  logic [63:0] out_reg;
  logic [63:0] core_res;
  logic        adv_out;
  logic        adv_in;

  assign adv_out = !out_vld || out_ch.ready;
  assign adv_in  = !in_vld || adv_out;
  assign in_ch.ready  = adv_in;
  assign out_ch.valid = out_vld;
  assign out_ch.data  = out_reg;

  fsp_core u_core (.op(in_reg), .scaled(core_res));

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (adv_in) begin
      in_vld <= in_ch.valid;
    end
    if (adv_in && in_ch.valid) begin
      in_reg <= in_ch.data;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv_out) begin
      out_vld <= in_vld;
    end
    if (adv_out && in_vld) begin
      out_reg <= core_res;
    end
  end

  `FSP_ASSERT_NEXT(a_hold, out_vld && !out_ch.ready, out_vld && $stable(out_reg))
  `FSP_ASSERT_NEXT(a_move, in_vld && adv_out, out_vld)
  `FSP_ASSERT_IMPL(a_single_hi, in_vld && in_reg.precision == PREC_SINGLE, core_res[63:32] == 32'd0)
endmodule

/* sv/fsp_core.sv */
// ----------------------------------------------------------------------------
// fsp_core
// Combinational scaling of one registered operand by 2^n.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module fsp_core (
  input  fsp_pkg::fsp_in_t op,
  output logic [63:0]      scaled
);
  import fsp_pkg::*;

  logic        dbl;
  logic [63:0] bits;
  logic [5:0]  mant;
  logic [10:0] expmax;
  logic [10:0] bias;
  logic [10:0] efield;
  logic [52:0] frac;
  logic        sign;
  logic [52:0] sig_norm;
  logic [5:0]  lz;
  logic [5:0]  lzadj;
  logic signed [34:0] e;
  logic signed [34:0] sh;
  logic [52:0] q;
  logic [52:0] rem;
  logic [52:0] half;
  logic [52:0] smask;
  logic [63:0] res;

  always_comb begin
    dbl    = (op.precision == PREC_DOUBLE);
    bits   = dbl ? op.value : {32'd0, op.value[31:0]};
    mant   = dbl ? 6'(F64_MANT) : 6'(F32_MANT);
    expmax = dbl ? F64_EXPMAX : F32_EXPMAX;
    bias   = dbl ? F64_BIAS : F32_BIAS;
    efield = dbl ? bits[62:52] : {3'd0, bits[30:23]};
    frac   = dbl ? {1'b0, bits[51:0]} : {30'd0, bits[22:0]};
    sign   = dbl ? bits[63] : bits[31];
    // leading zeros relative to the format's hidden-bit position
    lz     = clz53(frac);
    lzadj  = dbl ? lz : 6'(lz - 6'd29);
    if (efield == 11'd0) begin
      sig_norm = frac << lzadj;
      e = 35'sd1 - $signed({24'd0, bias}) - $signed({29'd0, lzadj});
    end else begin
      sig_norm = frac | (53'd1 << mant);
      e = $signed({24'd0, efield}) - $signed({24'd0, bias});
    end
    e     = e + 35'($signed(op.scale_factor));
    sh    = 35'sd1 - $signed({24'd0, bias}) - e;
    smask = (53'd1 << sh[5:0]) - 53'd1;
    q     = sig_norm >> sh[5:0];
    rem   = sig_norm & smask;
    half  = 53'd1 << 6'(sh[5:0] - 6'd1);
    res   = 64'd0;
    if (efield == expmax || (efield == 11'd0 && frac == 53'd0)) begin
      res = bits;
    end else if (e > $signed({24'd0, bias})) begin
      res = dbl ? {sign, F64_EXPMAX, 52'd0} : {32'd0, sign, F32_EXPMAX[7:0], 23'd0};
    end else if (sh <= 35'sd0) begin
      res = dbl ? {sign, 11'(e + 35'sd1023), sig_norm[51:0]}
                : {32'd0, sign, 8'(e + 35'sd127), sig_norm[22:0]};
    end else if (sh > 35'($signed({29'd0, mant})) + 35'sd1) begin
      res = dbl ? {sign, 63'd0} : {32'd0, sign, 31'd0};
    end else begin
      if (rem > half || (rem == half && q[0])) q = q + 53'd1;
      res = dbl ? {sign, 10'd0, q} : {32'd0, sign, q[30:0]};
    end
    scaled = res;
  end
endmodule
